// ===== hdl/lemq_pkg.sv =====
`default_nettype none

package lemq_pkg;

    // store geometry
    localparam int MAX_LINES = 1024;
    localparam int ADDR_W    = $clog2(MAX_LINES);
    localparam int CNT_W     = $clog2(MAX_LINES + 1);

    // multiplier operand widths: intercept difference by slope difference, or slope by query x
    localparam int MUL_A_W   = 50;
    localparam int MUL_B_W   = 34;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // geometry unit modes
    localparam logic GEOM_ENV = 1'b0;
    localparam logic GEOM_VAL = 1'b1;

    typedef struct packed {
        logic signed [31:0] slope;
        logic signed [47:0] intercept;
    } line_t;

    localparam int LINE_W = $bits(line_t);

    typedef struct packed {
        logic start;
        logic mode;
    } geom_req_t;

    typedef struct packed {
        logic               done;
        logic               ok;
        logic signed [63:0] value;
    } geom_rsp_t;

    // logical position to ring address
    function automatic logic [ADDR_W-1:0] lemq_phys(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0] k);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(base) + (CNT_W + 1)'(k);
        if (s >= (CNT_W + 1)'(MAX_LINES)) begin
            s = s - (CNT_W + 1)'(MAX_LINES);
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/line_envelope_max_query.sv =====
`default_nettype none

// channel   dir  tdata fields (low bit up)                         bits
// s_axis    in   opcode 2, slope 32, intercept 48, query_x 32       120
// m_axis    out  max_value 64, empty_flag, full_flag, kept_flag      72
//
// one item at a time; the next word is taken while a result waits in the output register
// query: one 34-step shift-add product per line evaluated; front lines are popped while the next is not below
// insert: entries are scanned and moved one at a time; an envelope test takes two products
// lines live in one 80-bit ring memory with a registered read
// reset clears the state, output valid, line count and ring base; memory contents need no clearing
module line_envelope_max_query (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [119:0] s_tdata,   // opcode, slope, intercept, query_x
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [71:0]       m_tdata    // max_value, empty_flag, full_flag, kept_flag
);
    import lemq_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_FIN      = 5'd1;
    localparam logic [4:0] S_SCAN_RD  = 5'd2;
    localparam logic [4:0] S_SCAN_CAP = 5'd3;
    localparam logic [4:0] S_LEFT_CAP = 5'd4;
    localparam logic [4:0] S_ENV_GO   = 5'd5;
    localparam logic [4:0] S_ENV_WAIT = 5'd6;
    localparam logic [4:0] S_SHR_RD   = 5'd7;
    localparam logic [4:0] S_SHR_WR   = 5'd8;
    localparam logic [4:0] S_PR_R     = 5'd9;
    localparam logic [4:0] S_PR_R_C1  = 5'd10;
    localparam logic [4:0] S_PR_R_C2  = 5'd11;
    localparam logic [4:0] S_PR_L     = 5'd12;
    localparam logic [4:0] S_PR_L_C1  = 5'd13;
    localparam logic [4:0] S_PR_L_C2  = 5'd14;
    localparam logic [4:0] S_DEL_RD   = 5'd15;
    localparam logic [4:0] S_DEL_WR   = 5'd16;
    localparam logic [4:0] S_Q_CAP    = 5'd17;
    localparam logic [4:0] S_VAL_GO   = 5'd18;
    localparam logic [4:0] S_VAL_WAIT = 5'd19;
    localparam logic [4:0] S_Q_NEXT   = 5'd20;

    localparam logic [1:0] CTX_INS  = 2'd0;
    localparam logic [1:0] CTX_PR_R = 2'd1;
    localparam logic [1:0] CTX_PR_L = 2'd2;

    localparam logic RET_PR_R = 1'b0;
    localparam logic RET_PR_L = 1'b1;

    logic [4:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   p_reg, p_next;
    logic [1:0]         ctx_reg, ctx_next;
    logic               ret_reg, ret_next;
    logic               first_reg, first_next;
    logic signed [31:0] m_reg, m_next;
    logic signed [47:0] c_reg, c_next;
    logic signed [31:0] x_reg, x_next;
    line_t              l_reg, l_next;
    line_t              mid_reg, mid_next;
    line_t              r_reg, r_next;
    logic signed [63:0] val_reg, val_next;
    logic signed [63:0] res_max_reg, res_max_next;
    logic               res_empty_reg, res_empty_next;
    logic               res_full_reg, res_full_next;
    logic               res_kept_reg, res_kept_next;
    logic               m_tvalid_reg;
    logic [71:0]        m_tdata_reg;

    logic               s_acc;
    logic               fin_go;
    logic [1:0]         in_op;
    line_t              nl;
    line_t              rd_line;
    logic [LINE_W-1:0]  rd_data;
    logic [CNT_W-1:0]   rd_k;
    logic               wr_en;
    logic [CNT_W-1:0]   wr_k;
    line_t              wr_line;
    geom_req_t          geom_req;
    geom_rsp_t          geom_rsp;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign fin_go   = (state_reg == S_FIN) && (!m_tvalid_reg || m_tready);
    assign in_op    = s_tdata[1:0];
    assign nl       = '{slope: m_reg, intercept: c_reg};
    assign rd_line  = line_t'(rd_data);

    // line storage ring
    lemq_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_LINES)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (lemq_phys(base_reg, wr_k)),
        .wr_data (wr_line),
        .rd_addr (lemq_phys(base_reg, rd_k)),
        .rd_data (rd_data)
    );

    // cross-product test and line evaluation
    lemq_geom u_geom (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (geom_req),
        .l_line   (l_reg),
        .mid_line (mid_reg),
        .r_line   (r_reg),
        .x        (x_reg),
        .rsp      (geom_rsp)
    );

    // sequencer
    always_comb begin
        state_next     = state_reg;
        base_next      = base_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        p_next         = p_reg;
        ctx_next       = ctx_reg;
        ret_next       = ret_reg;
        first_next     = first_reg;
        m_next         = m_reg;
        c_next         = c_reg;
        x_next         = x_reg;
        l_next         = l_reg;
        mid_next       = mid_reg;
        r_next         = r_reg;
        val_next       = val_reg;
        res_max_next   = res_max_reg;
        res_empty_next = res_empty_reg;
        res_full_next  = res_full_reg;
        res_kept_next  = res_kept_reg;
        rd_k           = '0;
        wr_en          = 1'b0;
        wr_k           = k_reg;
        wr_line        = nl;
        geom_req.start = 1'b0;
        geom_req.mode  = GEOM_ENV;

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    m_next         = s_tdata[33:2];
                    c_next         = s_tdata[81:34];
                    x_next         = s_tdata[113:82];
                    res_max_next   = '0;
                    res_empty_next = 1'b0;
                    res_full_next  = 1'b0;
                    res_kept_next  = 1'b0;
                    state_next     = S_FIN;
                    unique case (in_op)
                        OP_INSERT: begin
                            if (cnt_reg >= CNT_W'(MAX_LINES)) begin
                                res_full_next = 1'b1;
                            end else begin
                                k_next     = '0;
                                state_next = S_SCAN_RD;
                            end
                        end
                        OP_QUERY: begin
                            if (cnt_reg == '0) begin
                                res_empty_next = 1'b1;
                            end else begin
                                first_next = 1'b1;
                                state_next = S_Q_CAP;
                            end
                        end
                        OP_CLEAR: cnt_next = '0;
                        OP_NOP:   ;
                        default:  ;
                    endcase
                end
            end
            S_FIN: begin
                if (fin_go) begin
                    state_next = S_IDLE;
                end
            end
            // find the first line with slope not below the new one
            S_SCAN_RD: begin
                if (k_reg == cnt_reg) begin
                    p_next     = cnt_reg;
                    state_next = S_SHR_RD;
                end else begin
                    rd_k       = k_reg;
                    state_next = S_SCAN_CAP;
                end
            end
            S_SCAN_CAP: begin
                p_next = k_reg;
                if (rd_line.slope < m_reg) begin
                    k_next     = k_reg + CNT_W'(1);
                    state_next = S_SCAN_RD;
                end else if (rd_line.slope == m_reg) begin
                    if (rd_line.intercept >= c_reg) begin
                        state_next = S_FIN;
                    end else begin
                        // higher line of equal slope replaces it in place
                        wr_en      = 1'b1;
                        wr_k       = k_reg;
                        state_next = S_PR_R;
                    end
                end else begin
                    r_next   = rd_line;
                    mid_next = nl;
                    if (k_reg == '0) begin
                        k_next     = cnt_reg;
                        state_next = S_SHR_RD;
                    end else begin
                        rd_k       = k_reg - CNT_W'(1);
                        state_next = S_LEFT_CAP;
                    end
                end
            end
            S_LEFT_CAP: begin
                l_next     = rd_line;
                ctx_next   = CTX_INS;
                state_next = S_ENV_GO;
            end
            S_ENV_GO: begin
                geom_req.start = 1'b1;
                geom_req.mode  = GEOM_ENV;
                state_next     = S_ENV_WAIT;
            end
            S_ENV_WAIT: begin
                if (geom_rsp.done) begin
                    unique case (ctx_reg)
                        CTX_INS: begin
                            if (geom_rsp.ok) begin
                                k_next     = cnt_reg;
                                state_next = S_SHR_RD;
                            end else begin
                                state_next = S_FIN;
                            end
                        end
                        CTX_PR_R: begin
                            if (geom_rsp.ok) begin
                                state_next = S_PR_L;
                            end else begin
                                k_next     = p_reg + CNT_W'(1);
                                ret_next   = RET_PR_R;
                                state_next = S_DEL_RD;
                            end
                        end
                        default: begin
                            if (geom_rsp.ok) begin
                                res_kept_next = 1'b1;
                                state_next    = S_FIN;
                            end else begin
                                k_next     = p_reg - CNT_W'(1);
                                p_next     = p_reg - CNT_W'(1);
                                ret_next   = RET_PR_L;
                                state_next = S_DEL_RD;
                            end
                        end
                    endcase
                end
            end
            // open a slot at p, moving the tail up one entry at a time
            S_SHR_RD: begin
                if (k_reg == p_reg) begin
                    wr_en      = 1'b1;
                    wr_k       = p_reg;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_PR_R;
                end else begin
                    rd_k       = k_reg - CNT_W'(1);
                    state_next = S_SHR_WR;
                end
            end
            S_SHR_WR: begin
                wr_en      = 1'b1;
                wr_k       = k_reg;
                wr_line    = rd_line;
                k_next     = k_reg - CNT_W'(1);
                state_next = S_SHR_RD;
            end
            // right neighbor test
            S_PR_R: begin
                if ((CNT_W + 1)'(p_reg) + (CNT_W + 1)'(2) < (CNT_W + 1)'(cnt_reg)) begin
                    rd_k       = p_reg + CNT_W'(1);
                    state_next = S_PR_R_C1;
                end else begin
                    state_next = S_PR_L;
                end
            end
            S_PR_R_C1: begin
                mid_next   = rd_line;
                rd_k       = p_reg + CNT_W'(2);
                state_next = S_PR_R_C2;
            end
            S_PR_R_C2: begin
                r_next     = rd_line;
                l_next     = nl;
                ctx_next   = CTX_PR_R;
                state_next = S_ENV_GO;
            end
            // left neighbor test
            S_PR_L: begin
                if (p_reg >= CNT_W'(2)) begin
                    rd_k       = p_reg - CNT_W'(2);
                    state_next = S_PR_L_C1;
                end else begin
                    res_kept_next = 1'b1;
                    state_next    = S_FIN;
                end
            end
            S_PR_L_C1: begin
                l_next     = rd_line;
                rd_k       = p_reg - CNT_W'(1);
                state_next = S_PR_L_C2;
            end
            S_PR_L_C2: begin
                mid_next   = rd_line;
                r_next     = nl;
                ctx_next   = CTX_PR_L;
                state_next = S_ENV_GO;
            end
            // close the slot at k, moving the tail down
            S_DEL_RD: begin
                if ((CNT_W + 1)'(k_reg) + (CNT_W + 1)'(1) >= (CNT_W + 1)'(cnt_reg)) begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = (ret_reg == RET_PR_L) ? S_PR_L : S_PR_R;
                end else begin
                    rd_k       = k_reg + CNT_W'(1);
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                wr_en      = 1'b1;
                wr_k       = k_reg;
                wr_line    = rd_line;
                k_next     = k_reg + CNT_W'(1);
                state_next = S_DEL_RD;
            end
            // query: evaluate front lines, pop while the successor is not below
            S_Q_CAP: begin
                mid_next   = rd_line;
                state_next = S_VAL_GO;
            end
            S_VAL_GO: begin
                geom_req.start = 1'b1;
                geom_req.mode  = GEOM_VAL;
                state_next     = S_VAL_WAIT;
            end
            S_VAL_WAIT: begin
                if (geom_rsp.done) begin
                    if (first_reg) begin
                        val_next   = geom_rsp.value;
                        first_next = 1'b0;
                        state_next = S_Q_NEXT;
                    end else if (geom_rsp.value >= val_reg) begin
                        val_next   = geom_rsp.value;
                        base_next  = lemq_phys(base_reg, CNT_W'(1));
                        cnt_next   = cnt_reg - CNT_W'(1);
                        state_next = S_Q_NEXT;
                    end else begin
                        res_max_next = val_reg;
                        state_next   = S_FIN;
                    end
                end
            end
            S_Q_NEXT: begin
                if (cnt_reg >= CNT_W'(2)) begin
                    rd_k       = CNT_W'(1);
                    state_next = S_Q_CAP;
                end else begin
                    res_max_next = val_reg;
                    state_next   = S_FIN;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            base_reg     <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            base_reg  <= base_next;
            cnt_reg   <= cnt_next;
            if (fin_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        k_reg         <= k_next;
        p_reg         <= p_next;
        ctx_reg       <= ctx_next;
        ret_reg       <= ret_next;
        first_reg     <= first_next;
        m_reg         <= m_next;
        c_reg         <= c_next;
        x_reg         <= x_next;
        l_reg         <= l_next;
        mid_reg       <= mid_next;
        r_reg         <= r_next;
        val_reg       <= val_next;
        res_max_reg   <= res_max_next;
        res_empty_reg <= res_empty_next;
        res_full_reg  <= res_full_next;
        res_kept_reg  <= res_kept_next;
        if (fin_go) begin
            m_tdata_reg <= {5'b0, res_kept_reg, res_full_reg, res_empty_reg, res_max_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_LINES))
        else $error("line count above capacity");

    a_wr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (wr_k <= cnt_reg))
        else $error("write beyond end of live lines");

    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn |=> ((CNT_W + 1)'(cnt_reg) <= (CNT_W + 1)'($past(cnt_reg)) + (CNT_W + 1)'(1)))
        else $error("line count grew by more than one");

    a_geom_done: assert property (@(posedge aclk) disable iff (!aresetn)
        geom_rsp.done |-> (state_reg == S_ENV_WAIT || state_reg == S_VAL_WAIT))
        else $error("geometry result with no request outstanding");

    a_empty_query: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && in_op == OP_QUERY && cnt_reg == '0) |=> (state_reg == S_FIN))
        else $error("empty query did not finish at once");
`endif

endmodule

`default_nettype wire

// ===== hdl/lemq_ram.sv =====
`default_nettype none

module lemq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/lemq_mul.sv =====
`default_nettype none

module lemq_mul (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic signed [lemq_pkg::MUL_A_W-1:0] a,
    input  wire logic signed [lemq_pkg::MUL_B_W-1:0] b,
    output logic                                     done,
    output logic signed [lemq_pkg::MUL_P_W-1:0]      prod
);
    import lemq_pkg::*;

    localparam logic [MUL_CNT_W-1:0] LAST = MUL_CNT_W'(MUL_B_W - 1);

    logic                      busy_reg;
    logic                      done_reg;
    logic [MUL_CNT_W-1:0]      cnt_reg;
    logic signed [MUL_P_W-1:0] acc_reg;
    logic signed [MUL_P_W-1:0] mc_reg;
    logic [MUL_B_W-1:0]        bq_reg;
    logic signed [MUL_P_W-1:0] term;

    // partial product of the current multiplier bit
    assign term = bq_reg[0] ? mc_reg : '0;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + MUL_CNT_W'(1);
            end
        end
    end

    // shift-add datapath, top bit of b weighs negative
    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            acc_reg <= '0;
            mc_reg  <= MUL_P_W'(a);
            bq_reg  <= b;
        end else if (busy_reg) begin
            if (cnt_reg == LAST) begin
                acc_reg <= acc_reg - term;
            end else begin
                acc_reg <= acc_reg + term;
            end
            mc_reg <= mc_reg <<< 1;
            bq_reg <= bq_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

// ===== hdl/lemq_geom.sv =====
`default_nettype none

module lemq_geom (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire lemq_pkg::geom_req_t       req,
    input  wire lemq_pkg::line_t           l_line,
    input  wire lemq_pkg::line_t           mid_line,
    input  wire lemq_pkg::line_t           r_line,
    input  wire logic signed [31:0]        x,
    output lemq_pkg::geom_rsp_t            rsp
);
    import lemq_pkg::*;

    localparam logic [1:0] G_IDLE = 2'd0;
    localparam logic [1:0] G_P1   = 2'd1;
    localparam logic [1:0] G_P2   = 2'd2;

    logic [1:0]                gstate_reg;
    logic                      mode_reg;
    logic signed [MUL_P_W-1:0] prod1_reg;
    logic                      done_reg;
    logic                      ok_reg;
    logic signed [63:0]        value_reg;

    logic                      mul_start;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                      mul_done;
    logic signed [MUL_P_W-1:0] mul_prod;

    logic signed [48:0] dc_a;
    logic signed [32:0] dm_a;
    logic signed [48:0] dc_b;
    logic signed [32:0] dm_b;

    // differences for the two cross products
    assign dc_a = 49'(mid_line.intercept) - 49'(r_line.intercept);
    assign dm_a = 33'(mid_line.slope) - 33'(l_line.slope);
    assign dc_b = 49'(l_line.intercept) - 49'(mid_line.intercept);
    assign dm_b = 33'(r_line.slope) - 33'(mid_line.slope);

    // operand select
    always_comb begin
        if (gstate_reg == G_IDLE) begin
            if (req.mode == GEOM_ENV) begin
                mul_a = MUL_A_W'(dc_a);
                mul_b = MUL_B_W'(dm_a);
            end else begin
                mul_a = MUL_A_W'(mid_line.slope);
                mul_b = MUL_B_W'(x);
            end
        end else begin
            mul_a = MUL_A_W'(dc_b);
            mul_b = MUL_B_W'(dm_b);
        end
        mul_start = ((gstate_reg == G_IDLE) && req.start) ||
                    ((gstate_reg == G_P1) && mul_done && (mode_reg == GEOM_ENV));
    end

    lemq_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    // sequencing of one test or one evaluation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gstate_reg <= G_IDLE;
            done_reg   <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (gstate_reg)
                G_IDLE: begin
                    if (req.start) begin
                        gstate_reg <= G_P1;
                    end
                end
                G_P1: begin
                    if (mul_done) begin
                        if (mode_reg == GEOM_VAL) begin
                            done_reg   <= 1'b1;
                            gstate_reg <= G_IDLE;
                        end else begin
                            gstate_reg <= G_P2;
                        end
                    end
                end
                G_P2: begin
                    if (mul_done) begin
                        done_reg   <= 1'b1;
                        gstate_reg <= G_IDLE;
                    end
                end
                default: gstate_reg <= G_IDLE;
            endcase
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if ((gstate_reg == G_IDLE) && req.start) begin
            mode_reg <= req.mode;
        end
        if ((gstate_reg == G_P1) && mul_done) begin
            prod1_reg <= mul_prod;
            value_reg <= mul_prod[63:0] + 64'(mid_line.intercept);
        end
        if ((gstate_reg == G_P2) && mul_done) begin
            ok_reg <= prod1_reg > mul_prod;
        end
    end

    assign rsp = '{done: done_reg, ok: ok_reg, value: value_reg};

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lemq_pkg::*;

    localparam int STALL_LIMIT = 200000;

    typedef struct {
        logic signed [63:0] max_value;
        bit                 empty_flag;
        bit                 full_flag;
        bit                 kept_flag;
    } answer_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;   // opcode, slope, intercept, query_x
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;   // max_value, empty_flag, full_flag, kept_flag

    line_envelope_max_query i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // envelope copy kept by the testbench
    longint  env_slope [MAX_LINES];
    longint  env_icpt  [MAX_LINES];
    int      env_front;
    int      env_count;
    answer_t pending_answers[$];

    int errors;
    int words_sent;
    int stall_cycles;
    int hold_cycles;
    bit calm;

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // watchdog on cycles with no word moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d answers pending", pending_answers.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic bit random_idle();
        return !calm && ($urandom_range(99) < 23);
    endfunction

    // middle line strictly above where its neighbours cross
    function automatic bit middle_on_env(longint m1, longint c1, longint m2, longint c2,
                                         longint m3, longint c3);
        logic signed [127:0] lhs;
        logic signed [127:0] rhs;
        lhs = 128'(c2 - c3) * 128'(m2 - m1);
        rhs = 128'(c1 - c2) * 128'(m3 - m2);
        return lhs > rhs;
    endfunction

    function automatic bit slot_ok(int i);
        return middle_on_env(env_slope[i-1], env_icpt[i-1], env_slope[i], env_icpt[i],
                             env_slope[i+1], env_icpt[i+1]);
    endfunction

    function automatic void drop_slot(int i);
        for (int k = i; k + 1 < env_count; k++) begin
            env_slope[k] = env_slope[k+1];
            env_icpt[k]  = env_icpt[k+1];
        end
        env_count--;
    endfunction

    function automatic bit env_insert(longint m, longint c);
        int p;
        int n;
        n = env_count - env_front;
        for (int k = 0; k < n; k++) begin
            env_slope[k] = env_slope[env_front + k];
            env_icpt[k]  = env_icpt[env_front + k];
        end
        env_front = 0;
        env_count = n;
        p = 0;
        while (p < env_count && env_slope[p] < m) p++;
        if (p < env_count && env_slope[p] == m) begin
            if (env_icpt[p] >= c) return 1'b0;
            drop_slot(p);
        end
        if (p > 0 && p < env_count &&
            !middle_on_env(env_slope[p-1], env_icpt[p-1], m, c, env_slope[p], env_icpt[p]))
            return 1'b0;
        for (int k = env_count; k > p; k--) begin
            env_slope[k] = env_slope[k-1];
            env_icpt[k]  = env_icpt[k-1];
        end
        env_slope[p] = m;
        env_icpt[p]  = c;
        env_count++;
        while (p + 2 < env_count && !slot_ok(p + 1)) drop_slot(p + 1);
        while (p >= 2 && !slot_ok(p - 1)) begin
            drop_slot(p - 1);
            p--;
        end
        return 1'b1;
    endfunction

    function automatic longint line_at(int i, longint x);
        return env_slope[i] * x + env_icpt[i];
    endfunction

    function automatic answer_t predict_answer(logic [1:0] op, logic [31:0] m,
                                               logic [47:0] c, logic [31:0] x);
        answer_t a;
        longint  xs;
        a = '{0, 0, 0, 0};
        xs = longint'($signed(x));
        case (op)
            OP_INSERT: begin
                if (env_count - env_front >= MAX_LINES) a.full_flag = 1'b1;
                else a.kept_flag = env_insert(longint'($signed(m)), longint'($signed(c)));
            end
            OP_QUERY: begin
                if (env_count <= env_front) begin
                    a.empty_flag = 1'b1;
                end else begin
                    while (env_front + 1 < env_count &&
                           line_at(env_front + 1, xs) >= line_at(env_front, xs))
                        env_front++;
                    a.max_value = line_at(env_front, xs);
                end
            end
            OP_CLEAR: begin
                env_front = 0;
                env_count = 0;
            end
            default: ;
        endcase
        return a;
    endfunction

    // send one word, leaving tvalid up for the next call to decide
    task automatic send_word(logic [1:0] op, logic [31:0] m, logic [47:0] c,
                             logic [31:0] x);
        while (random_idle()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, x, c, m, op};
        do @(posedge aclk); while (!s_tready);
        pending_answers.push_back(predict_answer(op, m, c, x));
        words_sent++;
    endtask

    task automatic send_insert(longint m, longint c);
        send_word(OP_INSERT, m[31:0], c[47:0], 32'd0);
    endtask

    task automatic send_query(longint x);
        send_word(OP_QUERY, 32'(~x), 48'(x * 7), x[31:0]);
    endtask

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("%0t answer %s: got %0h expected %0h", $realtime, field, got, want);
    endtask

    // answer checker and receiver stalls
    always @(posedge aclk) begin
        answer_t want;
        if (m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected", m_tdata[63:0], 64'd0);
            end else begin
                want = pending_answers.pop_front();
                if (m_tdata[63:0] !== want.max_value)
                    report_mismatch("max_value", m_tdata[63:0], want.max_value);
                if (m_tdata[64] !== want.empty_flag)
                    report_mismatch("empty_flag", 64'(m_tdata[64]), 64'(want.empty_flag));
                if (m_tdata[65] !== want.full_flag)
                    report_mismatch("full_flag", 64'(m_tdata[65]), 64'(want.full_flag));
                if (m_tdata[66] !== want.kept_flag)
                    report_mismatch("kept_flag", 64'(m_tdata[66]), 64'(want.kept_flag));
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !random_idle();
        end
    end

    // edge cases: equal slopes, touching line, ties, empty store, nop, clear, extreme values
    task automatic test_directed();
        send_query(5);
        send_insert(0, 0);
        send_insert(0, 0);
        send_insert(0, -3);
        send_insert(0, 4);
        send_insert(-1, 0);
        send_insert(1, 0);
        send_insert(0, 0);
        send_query(-10);
        send_query(0);
        send_query(-4);
        send_query(50);
        send_word(OP_NOP, 32'hffff_ffff, 48'hffff_ffff_ffff, 32'hffff_ffff);
        send_word(OP_CLEAR, 32'd0, 48'd0, 32'd0);
        send_query(0);
        send_insert(-64'sd2147483648, -64'sd140737488355328);
        send_insert(64'sd2147483647, 64'sd140737488355327);
        send_insert(0, 64'sd140737488355327);
        send_query(-64'sd2147483648);
        send_query(0);
        send_query(64'sd2147483647);
        send_word(OP_CLEAR, 32'd0, 48'd0, 32'd0);
    endtask

    // fill the store to capacity with a concave family, then overflow it
    task automatic test_full_store();
        calm = 1'b1;
        for (int i = 0; i < MAX_LINES; i++) send_insert(i, -(i * i));
        send_insert(MAX_LINES + 5, 0);
        send_insert(3, 100);
        send_insert(-7, 0);
        send_query(MAX_LINES / 2);
        send_insert(-7, 0);
        send_word(OP_CLEAR, 32'd0, 48'd0, 32'd0);
        calm = 1'b0;
    endtask

    // receiver holds off while words keep coming
    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 20; i++) begin
            if (i % 3 == 2) send_query(i);
            else send_insert(int'($urandom_range(20)) - 10, int'($urandom_range(200)) - 100);
        end
        send_word(OP_CLEAR, 32'd0, 48'd0, 32'd0);
    endtask

    // random sets: mostly small values, some full range; x mostly rising
    task automatic test_random(int target);
        int     set_size;
        bit     wide;
        longint qx;
        int     pick;
        while (words_sent < target) begin
            wide = ($urandom_range(3) == 0);
            set_size = $urandom_range(40, 4);
            qx = wide ? longint'($signed($urandom())) : int'($urandom_range(30)) - 60;
            for (int i = 0; i < set_size; i++) begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    if (wide) send_word(OP_INSERT, $urandom(), {$urandom(), 16'($urandom())},
                                        $urandom());
                    else send_insert(int'($urandom_range(40)) - 20,
                                     int'($urandom_range(400)) - 200);
                end else if (pick < 93) begin
                    send_query(qx);
                    if (pick < 90) qx = qx + (wide ? $urandom_range(1 << 28) : $urandom_range(8));
                    else qx = qx - $urandom_range(10);
                    if (qx > 64'sd2147483647) qx = 64'sd2147483647;
                end else if (pick < 97) begin
                    send_word(OP_NOP, $urandom(), {$urandom(), 16'($urandom())}, $urandom());
                end else begin
                    send_word(OP_QUERY, $urandom(), {$urandom(), 16'($urandom())}, $urandom());
                end
            end
            send_word(OP_CLEAR, $urandom(), {$urandom(), 16'($urandom())}, $urandom());
        end
    endtask

    initial begin
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        m_tready     <= 1'b0;
        errors       = 0;
        words_sent   = 0;
        stall_cycles = 0;
        hold_cycles  = 0;
        calm         = 1'b0;
        env_front    = 0;
        env_count    = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_full_store();
        test_random(1300);
        s_tvalid <= 1'b0;

        wait (pending_answers.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/lemq_pkg.sv
hdl/lemq_ram.sv
hdl/lemq_mul.sv
hdl/lemq_geom.sv
hdl/line_envelope_max_query.sv
tb/sv/tb.sv
